// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bounding box checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define PBB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked through reset.
`define PBB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared constants, types and helpers of the paraboloid bounding box block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbb_pkg;

   // Default coordinate width (signed Q16.16).
   localparam int COORD_WIDTH_DEF = 32;

   // Control flags that travel with a word into the box stage.
   typedef struct packed {
      logic valid;
      logic dneg;
      logic degen;
   } box_ctl_type;

   // Round a bit count up to whole bytes.
   function automatic int round_bytes(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

// ===== design/pbb_sqrt.sv =====
// ----------------------------------------------------------------------------
// pbb_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbb_sqrt #(
   parameter int W  = 32,
   parameter int SW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  logic [2*W-1:0] radicand,
   input  logic [SW-1:0]  in_side,
   output logic           out_valid,
   output logic [W-1:0]   root,
   output logic [SW-1:0]  out_side
);

   localparam int RW = W + 2;

   logic           v_ff    [W];
   logic [2*W-1:0] rad_ff  [W];
   logic [RW-1:0]  rem_ff  [W];
   logic [W-1:0]   root_ff [W];
   logic [SW-1:0]  side_ff [W];

   for (genvar i = 0; i < W; i++) begin : g_stage
      localparam int K = W - 1 - i;
      logic           v_cur;
      logic [2*W-1:0] rad_cur;
      logic [RW-1:0]  rem_cur;
      logic [W-1:0]   root_cur;
      logic [SW-1:0]  side_cur;
      logic [RW+1:0]  part;
      logic [RW+1:0]  trial;
      logic           ge;
      logic [RW-1:0]  rem_in;
      logic [W-1:0]   root_in;

      if (i == 0) begin : g_first
         assign v_cur    = in_valid;
         assign rad_cur  = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign v_cur    = v_ff[i-1];
         assign rad_cur  = rad_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // Bring down the next pair of radicand bits and try the next root bit.
      assign part    = {rem_cur, rad_cur[2*K+1 -: 2]};
      assign trial   = {2'b00, root_cur, 2'b01};
      assign ge      = part >= trial;
      assign rem_in  = ge ? RW'(part - trial) : RW'(part);
      assign root_in = {root_cur[W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[i]  <= rad_cur;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_cur;
         end
      end
   end

   assign out_valid = v_ff[W-1];
   assign root      = root_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

// ===== design/pbb_div.sv =====
// ----------------------------------------------------------------------------
// pbb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbb_div #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           adv,
   input  logic [2*W-1:0] num,
   input  logic [W:0]     dvs,
   output logic [W-1:0]   quo
);

   logic [W:0]     rem_ff [W];
   logic [W-1:0]   quo_ff [W];
   logic [2*W-1:0] num_ff [W];
   logic [W:0]     dvs_ff [W];

   for (genvar i = 0; i < W; i++) begin : g_stage
      localparam int K = W - 1 - i;
      logic [W:0]     rem_cur;
      logic [W-1:0]   quo_cur;
      logic [2*W-1:0] num_cur;
      logic [W:0]     dvs_cur;
      logic [W+1:0]   part;
      logic           ge;
      logic [W:0]     rem_in;
      logic [W-1:0]   quo_in;

      // The quotient is known to fit in W bits, so the upper half of the
      // numerator starts out below the divisor.
      if (i == 0) begin : g_first
         assign rem_cur = {1'b0, num[2*W-1:W]};
         assign quo_cur = '0;
         assign num_cur = num;
         assign dvs_cur = dvs;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign quo_cur = quo_ff[i-1];
         assign num_cur = num_ff[i-1];
         assign dvs_cur = dvs_ff[i-1];
      end

      assign part   = {rem_cur, num_cur[K]};
      assign ge     = part >= {1'b0, dvs_cur};
      assign rem_in = ge ? (W+1)'(part - {1'b0, dvs_cur}) : part[W:0];
      assign quo_in = {quo_cur[W-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
            num_ff[i] <= num_cur;
            dvs_ff[i] <= dvs_cur;
         end
      end
   end

   assign quo = quo_ff[W-1];

endmodule

// ===== design/pbb_box.sv =====
// ----------------------------------------------------------------------------
// pbb_box
// Forms top point and base midpoint, then the saturated box corners.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbb_box #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  pbb_pkg::box_ctl_type  ctl,
   input  logic [2:0][W-1:0]     center,
   input  logic [2:0][W-1:0]     axis,
   input  logic [2:0][W-1:0]     quo,
   input  logic [W-1:0]          radius,
   output logic                  out_valid,
   output logic                  out_degen,
   output logic [2:0][W-1:0]     box_lo,
   output logic [2:0][W-1:0]     box_hi
);

   localparam logic signed [W+2:0] SAT_MAX = {4'b0000, {(W-1){1'b1}}};
   localparam logic signed [W+2:0] SAT_MIN = {4'b1111, {(W-1){1'b0}}};

   // Point stage
   logic                   v1_ff;
   logic                   degen1_ff;
   logic [W-1:0]           r1_ff;
   logic signed [W+1:0]    top1_ff  [3];
   logic signed [W+1:0]    base1_ff [3];
   logic signed [W+1:0]    top_in   [3];
   logic signed [W+1:0]    base_in  [3];

   // Bound stage
   logic                   v2_ff;
   logic                   degen2_ff;
   logic [2:0][W-1:0]      lo2_ff;
   logic [2:0][W-1:0]      hi2_ff;
   logic [2:0][W-1:0]      lo_in;
   logic [2:0][W-1:0]      hi_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [W+1:0] cs;
         logic signed [W+1:0] as;
         logic signed [W+1:0] qs;
         logic signed [W+1:0] twice;
         cs    = (W+2)'($signed(center[i]));
         as    = (W+2)'($signed(axis[i]));
         qs    = $signed({2'b00, quo[i]});
         twice = (cs <<< 1) - as;
         // Arithmetic shift rounds the half toward minus infinity.
         base_in[i] = twice >>> 1;
         if (ctl.degen) begin
            top_in[i] = cs;
         end else if (axis[i][W-1] ^ ctl.dneg) begin
            top_in[i] = cs - qs;
         end else begin
            top_in[i] = cs + qs;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [W+2:0] rs;
         logic signed [W+2:0] mn;
         logic signed [W+2:0] mx;
         logic signed [W+2:0] lo;
         logic signed [W+2:0] hi;
         rs = $signed({3'b000, r1_ff});
         if (top1_ff[i] < base1_ff[i]) begin
            mn = (W+3)'(top1_ff[i]);
            mx = (W+3)'(base1_ff[i]);
         end else begin
            mn = (W+3)'(base1_ff[i]);
            mx = (W+3)'(top1_ff[i]);
         end
         lo = mn - rs;
         hi = mx + rs;
         priority if (lo > SAT_MAX) begin
            lo_in[i] = SAT_MAX[W-1:0];
         end else if (lo < SAT_MIN) begin
            lo_in[i] = SAT_MIN[W-1:0];
         end else begin
            lo_in[i] = lo[W-1:0];
         end
         priority if (hi > SAT_MAX) begin
            hi_in[i] = SAT_MAX[W-1:0];
         end else if (hi < SAT_MIN) begin
            hi_in[i] = SAT_MIN[W-1:0];
         end else begin
            hi_in[i] = hi[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         degen1_ff <= ctl.degen;
         r1_ff     <= radius;
         top1_ff   <= top_in;
         base1_ff  <= base_in;
         degen2_ff <= degen1_ff;
         lo2_ff    <= lo_in;
         hi2_ff    <= hi_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_degen = degen2_ff;
   assign box_lo    = lo2_ff;
   assign box_hi    = hi2_ff;

endmodule

// ===== design/paraboloid_bounding_box.sv =====
// ----------------------------------------------------------------------------
// paraboloid_bounding_box
// Throughput: one word per cycle while the skid register is empty; the two
// chained square-root pipelines set the depth, each resolving one root bit
// per stage.
// Reset: synchronous and active high; it empties every stage and the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block takes a paraboloid (center and axis vector in signed Q16.16, length
// in unsigned Q15.16) and returns its axis-aligned bounding box.
//
// Data path, one register stage per step:
//   entry       register the request word
//   square      |a_i| and |a_i|^2 per axis
//   sum         a.a
//   sqrt #1     m = floor(sqrt(a.a)), COORD_WIDTH stages
//   product     len*m and d = 2*len - m
//   setup       |a_i|*|d| and 2*len*m
//   sqrt #2     r = floor(sqrt(2*len*m)), COORD_WIDTH stages, running beside
//   divide      q_i = |a_i|*|d| / (2*m), three dividers of COORD_WIDTH stages
//   points      top point c +- q, base midpoint floor(c - a/2)
//   bounds      per-axis min - r and max + r, saturated
//   output      output register with a one-word skid register behind it
//
// Flow control: the whole pipeline moves together while the skid register is
// empty. When the output register is held by the consumer, the word leaving
// the pipeline drops into the skid register, and the pipeline holds from the
// next cycle on. req_tready therefore comes straight from a flip-flop.

module paraboloid_bounding_box #(
   parameter int COORD_WIDTH = pbb_pkg::COORD_WIDTH_DEF,
   localparam int W      = COORD_WIDTH,
   localparam int REQ_DW = pbb_pkg::round_bytes(7 * COORD_WIDTH - 1),
   localparam int RSP_DW = pbb_pkg::round_bytes(6 * COORD_WIDTH)
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   // From bit 0 up: center_x, center_y, center_z, axis_x, axis_y, axis_z
   // (COORD_WIDTH each), length (COORD_WIDTH-1), zero padding.
   input  logic [REQ_DW-1:0] req_tdata,

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // From bit 0 up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
   // box_max_z (COORD_WIDTH each), zero padding.
   output logic [RSP_DW-1:0] rsp_tdata,
   // Bit 0: degenerate.
   output logic [0:0]        rsp_tuser
);

   localparam int SIDE1_W = 9 * W + (W - 1);
   localparam int SIDE2_W = 6 * W + 2;

   // The pipeline advances as long as the skid register is free.
   logic adv;

   // Entry stage
   logic                v0_ff;
   logic [2:0][W-1:0]   c0_ff;
   logic [2:0][W-1:0]   a0_ff;
   logic [W-2:0]        len0_ff;

   // Square stage
   logic                v1_ff;
   logic [2:0][W-1:0]   c1_ff;
   logic [2:0][W-1:0]   a1_ff;
   logic [2:0][W-1:0]   am1_ff;
   logic [2:0][2*W-1:0] sq1_ff;
   logic [W-2:0]        len1_ff;
   logic [2:0][W-1:0]   am_in;
   logic [2:0][2*W-1:0] sq_in;

   // Sum stage
   logic                v2_ff;
   logic [2*W-1:0]      sum2_ff;
   logic [SIDE1_W-1:0]  side2_ff;

   // First square root
   logic                v3;
   logic [W-1:0]        m3;
   logic [SIDE1_W-1:0]  side3;
   logic [2:0][W-1:0]   c3;
   logic [2:0][W-1:0]   a3;
   logic [2:0][W-1:0]   am3;
   logic [W-2:0]        len3;

   // Product stage
   logic                  v4_ff;
   logic [2:0][W-1:0]     c4_ff;
   logic [2:0][W-1:0]     a4_ff;
   logic [2:0][W-1:0]     am4_ff;
   logic [W-1:0]          m4_ff;
   logic [2*W-2:0]        plm4_ff;
   logic signed [W+1:0]   d4_ff;
   logic [2*W-2:0]        plm_in;
   logic signed [W+1:0]   d_in;

   // Setup stage
   logic                  v5_ff;
   logic [2:0][W-1:0]     c5_ff;
   logic [2:0][W-1:0]     a5_ff;
   logic [2:0][2*W-1:0]   num5_ff;
   logic [W:0]            dvs5_ff;
   logic [2*W-1:0]        rad5_ff;
   logic                  dneg5_ff;
   logic                  degen5_ff;
   logic [W-1:0]          dmag;
   logic [2:0][2*W-1:0]   num_in;

   // Second square root and dividers
   logic                  v6;
   logic [W-1:0]          r6;
   logic [SIDE2_W-1:0]    side6;
   logic [2:0][W-1:0]     q6;
   pbb_pkg::box_ctl_type  ctl6;

   // Box stages
   logic                  v8;
   logic                  degen8;
   logic [2:0][W-1:0]     lo8;
   logic [2:0][W-1:0]     hi8;

   // Output and skid registers
   logic                  out_valid_ff;
   logic [6*W-1:0]        out_data_ff;
   logic                  out_degen_ff;
   logic                  skid_valid_ff;
   logic [6*W-1:0]        skid_data_ff;
   logic                  skid_degen_ff;

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // ---------------------------------------------------------------- entry
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            c0_ff[i] <= req_tdata[i*W +: W];
            a0_ff[i] <= req_tdata[(3+i)*W +: W];
         end
         len0_ff <= req_tdata[6*W +: W-1];
      end
   end

   // --------------------------------------------------------------- square
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // The most negative value maps onto its magnitude 2^(W-1).
         am_in[i] = a0_ff[i][W-1] ? (~a0_ff[i] + 1'b1) : a0_ff[i];
         sq_in[i] = am_in[i] * am_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff   <= c0_ff;
         a1_ff   <= a0_ff;
         am1_ff  <= am_in;
         sq1_ff  <= sq_in;
         len1_ff <= len0_ff;
      end
   end

   // ------------------------------------------------------------------ sum
   // Three squares of at most 2^(2W-2) each still fit in 2W bits.
   always_ff @(posedge clock) begin
      if (adv) begin
         sum2_ff  <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
         side2_ff <= {len1_ff, am1_ff, a1_ff, c1_ff};
      end
   end

   // ------------------------------------------------------ axis magnitude
   pbb_sqrt #(
      .W  (W),
      .SW (SIDE1_W)
   ) u_sqrt_mag (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .radicand  (sum2_ff),
      .in_side   (side2_ff),
      .out_valid (v3),
      .root      (m3),
      .out_side  (side3)
   );

   assign {len3, am3, a3, c3} = side3;

   // -------------------------------------------------------------- product
   assign plm_in = len3 * m3;
   assign d_in   = $signed({2'b00, len3, 1'b0}) - $signed({2'b00, m3});

   always_ff @(posedge clock) begin
      if (adv) begin
         c4_ff   <= c3;
         a4_ff   <= a3;
         am4_ff  <= am3;
         m4_ff   <= m3;
         plm4_ff <= plm_in;
         d4_ff   <= d_in;
      end
   end

   // ---------------------------------------------------------------- setup
   // |d| stays below 2^W since both 2*len and m do.
   always_comb begin
      logic signed [W+1:0] dabs;
      dabs = d4_ff[W+1] ? -d4_ff : d4_ff;
      dmag = dabs[W-1:0];
      for (int i = 0; i < 3; i++) begin
         num_in[i] = am4_ff[i] * dmag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c5_ff     <= c4_ff;
         a5_ff     <= a4_ff;
         num5_ff   <= num_in;
         dvs5_ff   <= {m4_ff, 1'b0};
         rad5_ff   <= {plm4_ff, 1'b0};
         dneg5_ff  <= d4_ff[W+1];
         degen5_ff <= (m4_ff == '0);
      end
   end

   // --------------------------------------------------- radius and offsets
   pbb_sqrt #(
      .W  (W),
      .SW (SIDE2_W)
   ) u_sqrt_rad (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .radicand  (rad5_ff),
      .in_side   ({degen5_ff, dneg5_ff, a5_ff, c5_ff}),
      .out_valid (v6),
      .root      (r6),
      .out_side  (side6)
   );

   // With a zero axis the divisor is zero; the box stage ignores the quotient.
   for (genvar i = 0; i < 3; i++) begin : g_div
      pbb_div #(
         .W (W)
      ) u_div (
         .clock (clock),
         .adv   (adv),
         .num   (num5_ff[i]),
         .dvs   (dvs5_ff),
         .quo   (q6[i])
      );
   end

   assign ctl6.valid = v6;
   assign ctl6.degen = side6[6*W+1];
   assign ctl6.dneg  = side6[6*W];

   // ------------------------------------------------------------ box stages
   pbb_box #(
      .W (W)
   ) u_box (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl       (ctl6),
      .center    (side6[3*W-1:0]),
      .axis      (side6[6*W-1:3*W]),
      .quo       (q6),
      .radius    (r6),
      .out_valid (v8),
      .out_degen (degen8),
      .box_lo    (lo8),
      .box_hi    (hi8)
   );

   // ------------------------------------------------------- valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v4_ff <= v3;
         v5_ff <= v4_ff;
      end
   end

   // ------------------------------------------------------- output and skid
   // A word waiting in the skid register always goes out before the next
   // pipeline word, which keeps the order intact.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= adv && v8;
         end
      end else if (adv && v8) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_data_ff  <= skid_data_ff;
            out_degen_ff <= skid_degen_ff;
         end else begin
            out_data_ff  <= {hi8, lo8};
            out_degen_ff <= degen8;
         end
      end else if (adv && v8) begin
         skid_data_ff  <= {hi8, lo8};
         skid_degen_ff <= degen8;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = RSP_DW'(out_data_ff);
   assign rsp_tuser[0] = out_degen_ff;

endmodule

// ===== design/pbb_checker.sv =====
// ----------------------------------------------------------------------------
// pbb_checker
// Port-level checks of the paraboloid bounding box block, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pbb_checker #(
   parameter int COORD_WIDTH = pbb_pkg::COORD_WIDTH_DEF,
   localparam int W      = COORD_WIDTH,
   localparam int RSP_DW = pbb_pkg::round_bytes(6 * COORD_WIDTH)
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata
);

   // A held result word stays offered.
   `PBB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp word dropped while stalled")

   // A held result word keeps its data.
   `PBB_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp data changed while stalled")

   // Reset empties the output.
   `PBB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid set right after reset")

   // The request side only stalls while a result word is waiting.
   `PBB_ASSERT(a_stall_cause, clock, reset, !req_tready |-> rsp_tvalid, "req stalled with empty output")

   // Every box has min no greater than max on each axis.
   `PBB_ASSERT(a_box_order, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[W-1:0]) <= $signed(rsp_tdata[4*W-1:3*W])) && ($signed(rsp_tdata[2*W-1:W]) <= $signed(rsp_tdata[5*W-1:4*W])) && ($signed(rsp_tdata[3*W-1:2*W]) <= $signed(rsp_tdata[6*W-1:5*W])), "box min above max")

endmodule

bind paraboloid_bounding_box pbb_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_pbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/paraboloid_bounding_box_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paraboloid_bounding_box_tb
// Streams paraboloid descriptions into the bounding box block and compares
// every returned box with a predictor, under idle, stall and back-pressure.
// ----------------------------------------------------------------------------

module paraboloid_bounding_box_tb;

   localparam int W       = 32;
   localparam int REQ_DW  = pbb_pkg::round_bytes(7 * W - 1);
   localparam int RSP_DW  = pbb_pkg::round_bytes(6 * W);
   localparam int LATENCY = 2 * W + 7;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [W-2:0] length;
      logic [W-1:0] axis_z, axis_y, axis_x;
      logic [W-1:0] center_z, center_y, center_x;
   } paraboloid_type;

   typedef struct packed {
      logic         degenerate;
      logic [W-1:0] max_z, max_y, max_x;
      logic [W-1:0] min_z, min_y, min_x;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   paraboloid_type pending_shapes[$];
   box_type        expected_boxes[$];
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   bit             hold_off = 1'b0;
   bit             stimulus_done = 1'b0;
   int             error_count = 0;
   longint         cycle_count = 0;

   paraboloid_bounding_box #(.COORD_WIDTH(W)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // Integer square root, floor, of a value below 2^64.
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         probe = root | (64'd1 << b);
         if (probe * probe <= v && probe <= 64'hFFFF_FFFF) root = probe;
      end
      return root;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Bounding box of one paraboloid, bit exact with the block.
   function automatic box_type bound_paraboloid(input paraboloid_type p);
      longint c[3], a[3], base, top, lo, hi, d;
      longint unsigned mag, sum_sq, axis_len, radius, dmag, q;
      longint lo_v[3], hi_v[3];
      box_type b;
      c[0] = signed'(p.center_x); c[1] = signed'(p.center_y); c[2] = signed'(p.center_z);
      a[0] = signed'(p.axis_x);   a[1] = signed'(p.axis_y);   a[2] = signed'(p.axis_z);
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag = (a[i] < 0) ? -a[i] : a[i];
         sum_sq += mag * mag;
      end
      axis_len = floor_sqrt(sum_sq);
      radius = floor_sqrt((64'(p.length) * axis_len) << 1);
      d = longint'(64'(p.length) << 1) - longint'(axis_len);
      dmag = (d < 0) ? -d : d;
      for (int i = 0; i < 3; i++) begin
         base = (2 * c[i] - a[i]) >>> 1;  // halves toward minus infinity
         top = c[i];
         if (axis_len != 0) begin
            mag = (a[i] < 0) ? -a[i] : a[i];
            q = (mag * dmag) / (axis_len << 1);
            top += (((a[i] < 0) != (d < 0)) ? -longint'(q) : longint'(q));
         end
         lo = ((top < base) ? top : base) - longint'(radius);
         hi = ((top < base) ? base : top) + longint'(radius);
         lo_v[i] = clamp_coord(lo);
         hi_v[i] = clamp_coord(hi);
      end
      b.min_x = lo_v[0][W-1:0]; b.min_y = lo_v[1][W-1:0]; b.min_z = lo_v[2][W-1:0];
      b.max_x = hi_v[0][W-1:0]; b.max_y = hi_v[1][W-1:0]; b.max_z = hi_v[2][W-1:0];
      b.degenerate = (axis_len == 0);
      return b;
   endfunction

   // Driver: offers the oldest pending shape; prediction happens on acceptance.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_boxes.push_back(bound_paraboloid(paraboloid_type'(req_tdata[7*W-2:0])));
            void'(pending_shapes.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            // After a handshake the next word, if any, is chosen once here.
            if (pending_shapes.size() > 0) begin
               if ($urandom_range(99) >= send_idle_pct) begin
                  req_tvalid <= 1'b1;
                  req_tdata  <= REQ_DW'(pending_shapes[0]);
               end else begin
                  req_tvalid <= 1'b0;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted box with the oldest prediction.
   always @(posedge clock) begin
      box_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[6*W-1:0]};
            if (expected_boxes.size() == 0) begin
               $error("unexpected box word %h", got);
               error_count++;
            end else begin
               want = expected_boxes.pop_front();
               if (got.min_x !== want.min_x) begin
                  $error("box_min_x expected %h actual %h", want.min_x, got.min_x);
                  error_count++;
               end
               if (got.min_y !== want.min_y) begin
                  $error("box_min_y expected %h actual %h", want.min_y, got.min_y);
                  error_count++;
               end
               if (got.min_z !== want.min_z) begin
                  $error("box_min_z expected %h actual %h", want.min_z, got.min_z);
                  error_count++;
               end
               if (got.max_x !== want.max_x) begin
                  $error("box_max_x expected %h actual %h", want.max_x, got.max_x);
                  error_count++;
               end
               if (got.max_y !== want.max_y) begin
                  $error("box_max_y expected %h actual %h", want.max_y, got.max_y);
                  error_count++;
               end
               if (got.max_z !== want.max_z) begin
                  $error("box_max_z expected %h actual %h", want.max_z, got.max_z);
                  error_count++;
               end
               if (got.degenerate !== want.degenerate) begin
                  $error("degenerate expected %b actual %b", want.degenerate,
                         got.degenerate);
                  error_count++;
               end
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long back-pressure stretch, counted in its own process, while the sender
   // keeps offering words so the pipeline fills and drops req_tready.
   initial begin
      wait (!reset && pending_shapes.size() > 100);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic logic [W-1:0] random_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return W'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
         3: return W'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic paraboloid_type random_shape();
      paraboloid_type p;
      p.center_x = random_coord(); p.center_y = random_coord();
      p.center_z = random_coord();
      p.axis_x = random_coord(); p.axis_y = random_coord(); p.axis_z = random_coord();
      if ($urandom_range(9) == 0) begin
         p.axis_x = '0; p.axis_y = '0; p.axis_z = '0;
      end
      case ($urandom_range(3))
         0: p.length = (W-1)'($urandom_range(0, 32'h000F_FFFF));
         1: p.length = $urandom_range(1) ? '1 : '0;
         default: p.length = (W-1)'($urandom());
      endcase
      return p;
   endfunction

   task automatic add_shape(input logic [W-1:0] c, input logic [W-1:0] ax,
                            input logic [W-1:0] ay, input logic [W-1:0] az,
                            input logic [W-2:0] len);
      paraboloid_type p;
      p.center_x = c; p.center_y = ~c; p.center_z = c;
      p.axis_x = ax; p.axis_y = ay; p.axis_z = az; p.length = len;
      pending_shapes.push_back(p);
   endtask

   initial begin
      int phase_pct[4][2];
      phase_pct = '{'{0, 0}, '{53, 0}, '{0, 53}, '{12, 12}};
      // Directed part: zero axis (degenerate), field extremes, odd axes for
      // the floor-halving base point, and mixed-sign axes for corner order.
      add_shape('0, '0, '0, '0, '0);
      add_shape(32'h0001_0000, '0, '0, '0, 31'h7FFF_FFFF);
      add_shape(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
      add_shape(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
      add_shape(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, '0);
      add_shape(32'h0000_0003, 32'h0000_0001, '0, '0, 31'h0000_0001);
      add_shape(32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'h0000_0003, '0, 31'h0001_0000);
      add_shape(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                31'h0000_4000);
      add_shape(32'hFFF0_0000, '0, '0, 32'hFFFE_0000, 31'h0005_0000);
      add_shape(32'h7FFF_0000, 32'h0100_0000, '0, '0, 31'h7FFF_0000);
      add_shape(32'h8001_0000, '0, 32'hFF00_0000, '0, 31'h7FFF_0000);
      add_shape(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                31'h2AAA_AAAA);
      add_shape('0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 31'h5555_5555);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_pct[ph][0];
         stall_pct = phase_pct[ph][1];
         for (int k = 0; k < 235; k++) pending_shapes.push_back(random_shape());
         wait (pending_shapes.size() == 0);
      end
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done && expected_boxes.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_boxes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule
